### hdl/mstk_pkg.sv
// Shared types and constants for the Kruskal spanning tree block.
`default_nettype none
package mstk_pkg;
  localparam int unsigned MaxVertices = 16;
  localparam int unsigned MaxEdges    = 120;
  localparam int unsigned VtxW        = 4;
  localparam int unsigned WeightW     = 32;
  localparam int unsigned CountW      = 5;
  localparam int unsigned MaxResults  = 15;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_UF_INIT,
    ST_UF_RD,
    ST_UF_WAIT,
    ST_UF_FIND,
    ST_UF_DECIDE,
    ST_EMIT,
    ST_LAST,
    ST_CLEAR
  } state_e;

  // signed weight, then lower, then higher vertex
  function automatic logic edge_less(input logic [WeightW-1:0] wa, input logic [VtxW-1:0] la,
                                     input logic [VtxW-1:0] ha, input logic [WeightW-1:0] wb,
                                     input logic [VtxW-1:0] lb, input logic [VtxW-1:0] hb);
    logic [WeightW-1:0] ka;
    logic [WeightW-1:0] kb;
    ka = {~wa[WeightW-1], wa[WeightW-2:0]};
    kb = {~wb[WeightW-1], wb[WeightW-2:0]};
    if (ka != kb) return ka < kb;
    if (la != lb) return la < lb;
    return ha < hb;
  endfunction
endpackage
`default_nettype wire

### hdl/minimum_spanning_tree_kruskal.sv
// Top level: edge loader, insertion sorter, union-find and result emitter.
//
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready, tlast  tdata {weight,higher,lower}, tuser {present}
// m_axis    out  tvalid/tready, tlast  tdata {weight,to,from}, tuser {overflow,no_edges}
// cfg       in   cfg_we_i              cfg_wdata_i = vertex_count
//
// Items are accepted back to back while loading. After the last item the insertion
// sort orders the N stored edges (one compare-and-shift per cycle through a single
// store write port), then union-find checks the edges in sorted order, then the final
// item is sent and the parent table is reset. Input is not ready meanwhile. Each tree
// edge is held back one step so the final one can carry tlast. Reset needs no clearing
// pass; the edge store is only read below the fill count. Results stall in the output
// register until taken.
`default_nettype none
module minimum_spanning_tree_kruskal #(
  parameter int unsigned MAX_VERTICES = mstk_pkg::MaxVertices,
  parameter int unsigned MAX_EDGES    = mstk_pkg::MaxEdges
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // lower_vertex[3:0], higher_vertex[7:4], edge_weight[39:8]
  input  wire logic [0:0]  s_axis_tuser,  // present[0]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // tree_from[3:0], tree_to[7:4], tree_weight[39:8]
  output logic [1:0]       m_axis_tuser,  // no_edges[0], overflow[1]
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i
);
  localparam int unsigned VW  = mstk_pkg::VtxW;
  localparam int unsigned WW  = mstk_pkg::WeightW;
  localparam int unsigned EW  = 2*VW + WW;
  localparam int unsigned AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned NW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned PW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned WKW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned RW  = $clog2(mstk_pkg::MaxResults + 1);

  mstk_pkg::state_e state_q, state_d;

  logic [EW-1:0] store_q [MAX_EDGES];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  logic [PW-1:0] parent_q [MAX_VERTICES];
  logic [NW-1:0] total_q, total_d;
  logic          drop_q, drop_d;
  logic [4:0]    vcount_q;
  logic [NW-1:0] i_q, i_d, j_q, j_d;
  logic [EW-1:0] key_q, key_d, cur_q, cur_d, hold_q, hold_d;
  logic [PW-1:0] ru_q, ru_d, rv_q, rv_d;
  logic [WKW-1:0] walk_q, walk_d;
  logic          side_q, side_d;
  logic [RW-1:0] cnt_q, cnt_d;
  logic          found_q, found_d;
  logic          ov_q, ov_d;
  logic [EW-1:0] ob_q, ob_d;
  logic          onone_q, onone_d, olast_q, olast_d, oov_q, oov_d;
  logic          par_we;
  logic [PW-1:0] par_wa, par_wd;

  logic [VW-1:0] in_lo, in_hi;
  logic [WW-1:0] in_w;
  logic          in_ok, acc, out_free, key_lt;
  logic [6:0]    nv;
  logic [PW-1:0] cur_node, cur_par;

  assign in_lo = s_axis_tdata[VW-1:0];
  assign in_hi = s_axis_tdata[2*VW-1:VW];
  assign in_w  = s_axis_tdata[EW-1:2*VW];
  assign nv    = (32'(vcount_q) < MAX_VERTICES) ? 7'(vcount_q) : 7'(MAX_VERTICES);
  assign in_ok = s_axis_tuser[0] && (in_lo < in_hi) && (7'(in_hi) < nv);
  assign s_axis_tready = (state_q == mstk_pkg::ST_LOAD);
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign cur_node = side_q ? rv_q : ru_q;
  assign cur_par  = parent_q[cur_node];
  assign key_lt   = mstk_pkg::edge_less(key_q[EW-1:2*VW], key_q[VW-1:0], key_q[2*VW-1:VW],
                                        rd_q[EW-1:2*VW], rd_q[VW-1:0], rd_q[2*VW-1:VW]);

  always_ff @(posedge clk_i) begin
    if (we) store_q[waddr] <= wdata;
    rd_q <= store_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_VERTICES; k++) parent_q[k] <= PW'(k);
    end else if (par_we) begin
      parent_q[par_wa] <= par_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mstk_pkg::ST_LOAD;
      total_q <= '0; drop_q <= 1'b0; vcount_q <= 5'd16;
      i_q <= '0; j_q <= '0; walk_q <= '0; side_q <= 1'b0; cnt_q <= '0;
      found_q <= 1'b0; ov_q <= 1'b0; m_axis_tvalid <= 1'b0;
      ob_q <= '0; onone_q <= 1'b0; olast_q <= 1'b0; oov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d; drop_q <= drop_d;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      i_q <= i_d; j_q <= j_d; walk_q <= walk_d; side_q <= side_d; cnt_q <= cnt_d;
      found_q <= found_d; ov_q <= ov_d;
      ob_q <= ob_d; onone_q <= onone_d; olast_q <= olast_d; oov_q <= oov_d;
      if (out_free) m_axis_tvalid <= (state_q == mstk_pkg::ST_EMIT) ||
                                     (state_q == mstk_pkg::ST_LAST);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d; cur_q <= cur_d; hold_q <= hold_d; ru_q <= ru_d; rv_q <= rv_d;
  end

  assign m_axis_tdata = ob_q;
  assign m_axis_tuser = {oov_q, onone_q};
  assign m_axis_tlast = olast_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mstk_pkg::ST_LOAD:
        if (acc && s_axis_tlast) state_d = mstk_pkg::ST_SORT_RD;
      mstk_pkg::ST_SORT_RD:
        if (i_q >= total_q) state_d = mstk_pkg::ST_UF_INIT;
        else state_d = mstk_pkg::ST_SORT_KEY;
      mstk_pkg::ST_SORT_KEY: state_d = mstk_pkg::ST_SORT_CMP;
      mstk_pkg::ST_SORT_CMP:
        if (!key_lt) state_d = mstk_pkg::ST_SORT_RD;
        else if (j_q == NW'(1)) state_d = mstk_pkg::ST_SORT_PUT;
      mstk_pkg::ST_SORT_PUT: state_d = mstk_pkg::ST_SORT_RD;
      mstk_pkg::ST_UF_INIT:  state_d = mstk_pkg::ST_UF_RD;
      mstk_pkg::ST_UF_RD:
        if (i_q >= total_q || cnt_q == RW'(mstk_pkg::MaxResults))
          state_d = mstk_pkg::ST_LAST;
        else state_d = mstk_pkg::ST_UF_WAIT;
      mstk_pkg::ST_UF_WAIT: state_d = mstk_pkg::ST_UF_FIND;
      mstk_pkg::ST_UF_FIND:
        if ((cur_par == cur_node || walk_q == WKW'(MAX_VERTICES)) && side_q)
          state_d = mstk_pkg::ST_UF_DECIDE;
      mstk_pkg::ST_UF_DECIDE:
        if (ru_q != rv_q && found_q) state_d = mstk_pkg::ST_EMIT;
        else state_d = mstk_pkg::ST_UF_RD;
      mstk_pkg::ST_EMIT: if (out_free) state_d = mstk_pkg::ST_UF_RD;
      mstk_pkg::ST_LAST: if (out_free) state_d = mstk_pkg::ST_CLEAR;
      mstk_pkg::ST_CLEAR:
        if (walk_q == WKW'(MAX_VERTICES - 1)) state_d = mstk_pkg::ST_LOAD;
      default: state_d = mstk_pkg::ST_LOAD;
    endcase
  end

  // datapath
  always_comb begin
    total_d = total_q; drop_d = drop_q; i_d = i_q; j_d = j_q;
    key_d = key_q; cur_d = cur_q; hold_d = hold_q; ru_d = ru_q; rv_d = rv_q;
    walk_d = walk_q; side_d = side_q; cnt_d = cnt_q; found_d = found_q; ov_d = ov_q;
    ob_d = ob_q; onone_d = onone_q; olast_d = olast_q; oov_d = oov_q;
    we = 1'b0; waddr = '0; wdata = key_q; raddr = '0;
    par_we = 1'b0; par_wa = '0; par_wd = '0;
    case (state_q)
      mstk_pkg::ST_LOAD: begin
        if (acc && in_ok) begin
          if (32'(total_q) < MAX_EDGES) begin
            we = 1'b1; waddr = AW'(total_q); wdata = {in_w, in_hi, in_lo};
            total_d = total_q + NW'(1);
          end else drop_d = 1'b1;
        end
        if (acc && s_axis_tlast) begin
          i_d = NW'(1); j_d = NW'(0);
          ov_d = drop_d;
        end
      end
      mstk_pkg::ST_SORT_RD: begin
        // fetch the next key
        raddr = AW'(i_q); j_d = i_q;
        if (i_q >= total_q) begin i_d = '0; walk_d = '0; end
      end
      mstk_pkg::ST_SORT_KEY: begin
        key_d = rd_q;
        raddr = AW'(j_q - NW'(1));
      end
      mstk_pkg::ST_SORT_CMP: begin
        if (key_lt) begin
          // shift the heavier entry up, fetch the one below
          we = 1'b1; waddr = AW'(j_q); wdata = rd_q;
          j_d = j_q - NW'(1);
          raddr = AW'(j_q - NW'(2));
        end else begin
          we = 1'b1; waddr = AW'(j_q); wdata = key_q;
          i_d = i_q + NW'(1);
        end
      end
      mstk_pkg::ST_SORT_PUT: begin
        we = 1'b1; waddr = '0; wdata = key_q;
        i_d = i_q + NW'(1);
      end
      mstk_pkg::ST_UF_INIT: begin
        i_d = '0; cnt_d = '0; found_d = 1'b0;
      end
      mstk_pkg::ST_UF_RD: raddr = AW'(i_q);
      mstk_pkg::ST_UF_WAIT: begin
        cur_d = rd_q; ru_d = PW'(rd_q[VW-1:0]); rv_d = PW'(rd_q[2*VW-1:VW]);
        walk_d = '0; side_d = 1'b0;
      end
      mstk_pkg::ST_UF_FIND: begin
        if (cur_par == cur_node || walk_q == WKW'(MAX_VERTICES)) begin
          side_d = 1'b1; walk_d = '0;
        end else begin
          walk_d = walk_q + WKW'(1);
          if (side_q) rv_d = cur_par; else ru_d = cur_par;
        end
      end
      mstk_pkg::ST_UF_DECIDE: begin
        i_d = i_q + NW'(1);
        if (ru_q != rv_q) begin
          par_we = 1'b1; par_wa = ru_q; par_wd = rv_q;
          cnt_d = cnt_q + RW'(1);
          // hold the first tree edge; later ones go through the emit state
          if (!found_q) begin
            hold_d = cur_q; found_d = 1'b1;
          end
        end
      end
      mstk_pkg::ST_EMIT: begin
        if (out_free) begin
          ob_d = hold_q; onone_d = 1'b0; oov_d = ov_q; olast_d = 1'b0;
          hold_d = cur_q;
        end
      end
      mstk_pkg::ST_LAST: begin
        if (out_free) begin
          ob_d = found_q ? hold_q : '0;
          onone_d = !found_q; oov_d = ov_q; olast_d = 1'b1;
        end
        walk_d = '0;
      end
      mstk_pkg::ST_CLEAR: begin
        par_we = 1'b1; par_wa = PW'(walk_q); par_wd = PW'(walk_q);
        if (walk_q != WKW'(MAX_VERTICES - 1)) walk_d = walk_q + WKW'(1);
        total_d = '0; drop_d = 1'b0;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mstk_pkg::ST_LOAD) |-> !s_axis_tready) else $error("accept while busy");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= MAX_EDGES) else $error("edge count beyond store");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RW'(mstk_pkg::MaxResults)) else $error("too many results");
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast) else $error("empty not last");
`endif
endmodule
`default_nettype wire
